FILE: hw/rtl/sdsdec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sdsdec_pkg;

    localparam logic [7:0] ESC_BYTE = 8'h80;
    localparam logic [7:0] ESC_LONG = 8'h01;

    localparam logic MOVE_NORMAL = 1'b0;
    localparam logic MOVE_TRIM   = 1'b1;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       block_start;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic               move_kind;
    } t_out_item;

    // parser result for the byte currently presented
    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_parse_res;

    // short delta: 0x81..0xff negative, 0x80 reads as +128
    function automatic logic [15:0] short_delta(input logic [7:0] b);
        logic neg;
        neg = b[7] && (b != ESC_BYTE);
        return {{8{neg}}, b};
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sdsdec_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module sdsdec_parser (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_advance,
    input  wire sdsdec_pkg::t_in_item i_item,
    output sdsdec_pkg::t_parse_res    o_res
);

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_SECOND,
        PH_DX_HI,
        PH_DX_LO,
        PH_DY_HI,
        PH_DY_LO,
        PH_IGN_HI,
        PH_IGN_LO
    } t_phase;

    t_phase      r_phase, n_phase, w_phase;
    logic [7:0]  r_first, n_first;
    logic [15:0] r_long_dx, n_long_dx;
    logic [15:0] r_long_dy, n_long_dy;

    // block start forces the phase back before the byte is consumed
    assign w_phase = i_item.block_start ? PH_FIRST : r_phase;

    always_comb begin
        n_phase   = w_phase;
        n_first   = r_first;
        n_long_dx = r_long_dx;
        n_long_dy = r_long_dy;
        o_res     = '0;
        case (w_phase)
            PH_FIRST: begin
                n_first = i_item.byte_in;
                n_phase = PH_SECOND;
            end
            PH_SECOND: begin
                if (r_first == sdsdec_pkg::ESC_BYTE) begin
                    n_phase = (i_item.byte_in == sdsdec_pkg::ESC_LONG) ? PH_DX_HI : PH_FIRST;
                end else begin
                    n_phase              = PH_FIRST;
                    o_res.valid          = 1'b1;
                    o_res.item.dx        = sdsdec_pkg::short_delta(r_first);
                    o_res.item.dy        = sdsdec_pkg::short_delta(i_item.byte_in);
                    o_res.item.move_kind = sdsdec_pkg::MOVE_NORMAL;
                end
            end
            PH_DX_HI: begin
                n_long_dx = {i_item.byte_in, 8'h00};
                n_phase   = PH_DX_LO;
            end
            PH_DX_LO: begin
                n_long_dx = {r_long_dx[15:8], i_item.byte_in};
                n_phase   = PH_DY_HI;
            end
            PH_DY_HI: begin
                n_long_dy = {i_item.byte_in, 8'h00};
                n_phase   = PH_DY_LO;
            end
            PH_DY_LO: begin
                n_long_dy = {r_long_dy[15:8], i_item.byte_in};
                n_phase   = PH_IGN_HI;
            end
            PH_IGN_HI: begin
                n_phase = PH_IGN_LO;
            end
            PH_IGN_LO: begin
                n_phase              = PH_FIRST;
                o_res.valid          = 1'b1;
                o_res.item.dx        = r_long_dx;
                o_res.item.dy        = r_long_dy;
                o_res.item.move_kind = sdsdec_pkg::MOVE_TRIM;
            end
            default: begin
                n_phase = PH_FIRST;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
        end else if (i_advance) begin
            r_phase <= n_phase;
        end
        if (i_advance) begin
            r_first   <= n_first;
            r_long_dx <= n_long_dx;
            r_long_dy <= n_long_dy;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/stitch_delta_stream_decoder_core.sv
// path: the last byte of a result passes one input register, then the parser
//   logic into the result register that drives o_out_*
// throughput: one byte per cycle while the output is not stalled by i_out_stall
// reset: synchronous active-low i_rst_n empties both registers and returns the
//   parser to expecting the first byte of a pair
`timescale 1ns / 1ps
`default_nettype none

module stitch_delta_stream_decoder_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire sdsdec_pkg::t_in_item  i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output sdsdec_pkg::t_out_item      o_out_item
);

    logic                  r_in_valid;
    sdsdec_pkg::t_in_item  r_in_item;
    logic                  r_out_valid;
    sdsdec_pkg::t_out_item r_out_item;
    sdsdec_pkg::t_parse_res w_res;
    logic                  w_advance;
    logic                  w_in_accept;

    // the held byte moves on when the result register is free or draining
    assign w_advance   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_advance;
    assign w_in_accept = i_in_valid && !o_in_stall;

    sdsdec_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (r_in_item),
        .o_res     (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= w_res.valid;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_in_accept) begin
            r_in_item <= i_in_item;
        end
        if (w_advance && w_res.valid) begin
            r_out_item <= w_res.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // a held byte that cannot move on stays held
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in_item))
        else $error("held input transaction lost");

    // a parsed result always reaches the output register
    a_res_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && w_res.valid |=> o_out_valid && (o_out_item == $past(w_res.item)))
        else $error("parsed result not presented");

    // reset leaves both stages empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("stages not empty after reset");

endmodule

`default_nettype wire
